// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL files; all assertions are sampled on
// the rising edge of clk and are off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in every cycle.
`define FCCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle that forces a condition in the next cycle.
`define FCCM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/fccm_pkg.sv
// ----------------------------------------------------------------------------
// fccm_pkg
// Types and constants of the four color cell mapper.
// ----------------------------------------------------------------------------
package fccm_pkg;

  localparam int MAX_FRAMES_DEF = 256;

  // Input queue between the front and the back part.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam int TDATA_OUT_W = 56;

  // Frame layout, in cells and pixels.
  localparam logic [10:0] CELLS_LAST    = 11'd1151;
  localparam logic [10:0] TOP_CELLS     = 11'd864;
  localparam logic [10:0] RIGHT_END     = 11'd1008;
  localparam logic [9:0]  CELL_SIZE     = 10'd20;
  localparam logic [9:0]  TOP_X_FIRST   = 10'd120;
  localparam logic [9:0]  TOP_X_LAST    = 10'd580;
  localparam logic [9:0]  RIGHT_X_FIRST = 10'd600;
  localparam logic [9:0]  RIGHT_X_LAST  = 10'd700;
  localparam logic [9:0]  LEFT_X_FIRST  = 10'd0;
  localparam logic [9:0]  LEFT_X_LAST   = 10'd100;
  localparam logic [9:0]  SIDE_Y_FIRST  = 10'd120;

  localparam logic [7:0]  LEVEL_ON = 8'd255;

  // Symbol slot within one byte; the terminator takes the slot after the
  // fourth pair.
  localparam logic [2:0] SLOT_FIRST = 3'd0;
  localparam logic [2:0] SLOT_LAST  = 3'd3;
  localparam logic [2:0] SLOT_TERM  = 3'd4;

  localparam logic [1:0] SYM_BLACK = 2'd0;
  localparam logic [1:0] SYM_RED   = 2'd1;
  localparam logic [1:0] SYM_GREEN = 2'd2;
  localparam logic [1:0] SYM_BLUE  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_index;
    logic [9:0] cell_x;
    logic [9:0] cell_y;
    logic [1:0] symbol_code;
    logic [7:0] blue_level;
    logic [7:0] green_level;
    logic [7:0] red_level;
    logic       end_symbol;
    logic       last_of_run;
  } result_t;

  // Handshake between queue head and the back part.
  typedef struct packed {
    logic valid;
    logic full;
  } queue_stat_t;

endpackage

// File: hw/rtl/four_color_cell_mapper.sv
// ----------------------------------------------------------------------------
// four_color_cell_mapper
// Maps message bytes to colored 20x20 cells of a 720x720 frame.
// ----------------------------------------------------------------------------
// Each byte taken on the input stream is split into four 2-bit symbols, most
// significant pair first, and every symbol leaves as one output transfer with
// its color (00 black, 01 red, 10 green, 11 blue) and the next free cell of
// the frame. A frame has 1152 cells: a 24-wide by 36-high block at x=120,
// y=0, then a 6-wide by 24-high block at x=600, y=120, then the same at
// x=0, y=120, each walked row by row; when a frame is full the frame number
// steps on, modulo MAX_FRAMES. The byte flagged by tlast is followed by one
// black terminator symbol (tuser high) if its frame still has a free cell,
// and the next message then starts over at cell 0 of frame 0. tlast on the
// output marks the final transfer caused by each input byte. The block
// emits one symbol per clock while a byte is queued and the output is not
// stalled; that rate is set by the symbol sequencer of the back part, which
// owns the single output register. A two-entry queue in front of the
// sequencer keeps taking bytes, until it is full, while results wait to be taken.
// ----------------------------------------------------------------------------
module four_color_cell_mapper #(
  parameter int MAX_FRAMES = fccm_pkg::MAX_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: data_byte [7:0]
  input  logic [7:0]                       s_tdata,
  // s_tlast: last_byte
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: frame_index [7:0], cell_x [17:8], cell_y [27:18],
  // symbol_code [29:28], blue_level [37:30], green_level [45:38],
  // red_level [53:46], zero fill [55:54]
  output logic [fccm_pkg::TDATA_OUT_W-1:0] m_tdata,
  // m_tuser: end_symbol
  output logic                             m_tuser,
  // m_tlast: last_of_run
  output logic                             m_tlast
);
  import fccm_pkg::*;

  `include "assert_macros.svh"

  item_t       head;
  queue_stat_t stat;
  logic        pop;
  result_t     result;

  fccm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  fccm_back #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  assign m_tdata = {2'b00, result.red_level, result.green_level, result.blue_level,
                    result.symbol_code, result.cell_y, result.cell_x,
                    result.frame_index};
  assign m_tuser = result.end_symbol;
  assign m_tlast = result.last_of_run;

  // The terminator always closes the run of its byte.
  `FCCM_ASSERT(a_term_is_last, !(m_tvalid && m_tuser) || m_tlast, "terminator without tlast")
  // The terminator is black and never sits in the first cell of a frame.
  `FCCM_ASSERT(a_term_shape, !(m_tvalid && m_tuser) || ((result.symbol_code == SYM_BLACK) && (result.red_level == 8'd0) && !((result.cell_x == TOP_X_FIRST) && (result.cell_y == 10'd0))), "bad terminator")
  // The sequencer only takes a byte that the queue holds.
  `FCCM_ASSERT(a_pop_valid, !pop || stat.valid, "pop from empty queue")
  // A byte taken into an empty queue is at its head in the next cycle.
  `FCCM_ASSERT_NEXT(a_push_seen, s_tvalid && s_tready && !stat.valid, stat.valid, "lost byte")

endmodule

// File: hw/rtl/fccm_front.sv
// ----------------------------------------------------------------------------
// fccm_front
// Accepts message bytes and holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
module fccm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  input  logic                pop,
  output fccm_pkg::item_t     head,
  output fccm_pkg::queue_stat_t stat
);
  import fccm_pkg::*;

  item_t              entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               do_pop;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign s_tready   = !stat.full;
  assign push       = s_tvalid && s_tready;
  assign do_pop     = pop && stat.valid;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{data_byte: s_tdata, last_byte: s_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/fccm_back.sv
// ----------------------------------------------------------------------------
// fccm_back
// Walks the cells of the frame and emits one colored symbol per cycle into
// an output register while a byte is queued and the output is not stalled.
// ----------------------------------------------------------------------------
module fccm_back #(
  parameter int MAX_FRAMES = fccm_pkg::MAX_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fccm_pkg::item_t       head,
  input  fccm_pkg::queue_stat_t stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fccm_pkg::result_t     result
);
  import fccm_pkg::*;

  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [10:0]   pos;
  logic [9:0]    cur_x;
  logic [9:0]    cur_y;
  logic [FW-1:0] frame;
  logic [2:0]    slot;

  logic [10:0]   pos_next;
  logic [9:0]    x_next;
  logic [9:0]    y_next;
  logic [FW-1:0] frame_next;
  logic          wrap;
  logic [9:0]    x_first;
  logic [9:0]    x_last;
  logic          step;
  logic          is_term;
  logic          run_end;
  logic          restart;
  logic [1:0]    sym;
  logic [FW+7:0] frame_ext;

  assign step    = stat.valid && (!out_valid || out_ready);
  assign is_term = (slot == SLOT_TERM);

  always_comb begin
    case (slot[1:0])
      2'd0:    sym = head.data_byte[7:6];
      2'd1:    sym = head.data_byte[5:4];
      2'd2:    sym = head.data_byte[3:2];
      default: sym = head.data_byte[1:0];
    endcase
    if (is_term) begin
      sym = SYM_BLACK;
    end
  end

  // Next free cell, walking each region row by row.
  always_comb begin
    if (pos < TOP_CELLS) begin
      x_first = TOP_X_FIRST;
      x_last  = TOP_X_LAST;
    end else if (pos < RIGHT_END) begin
      x_first = RIGHT_X_FIRST;
      x_last  = RIGHT_X_LAST;
    end else begin
      x_first = LEFT_X_FIRST;
      x_last  = LEFT_X_LAST;
    end
    wrap     = (pos == CELLS_LAST);
    pos_next = pos + 1'b1;
    x_next   = cur_x + CELL_SIZE;
    y_next   = cur_y;
    if (wrap) begin
      pos_next = '0;
      x_next   = TOP_X_FIRST;
      y_next   = '0;
    end else if (pos == TOP_CELLS - 1'b1) begin
      x_next = RIGHT_X_FIRST;
      y_next = SIDE_Y_FIRST;
    end else if (pos == RIGHT_END - 1'b1) begin
      x_next = LEFT_X_FIRST;
      y_next = SIDE_Y_FIRST;
    end else if (cur_x == x_last) begin
      x_next = x_first;
      y_next = cur_y + CELL_SIZE;
    end
    if (!wrap) begin
      frame_next = frame;
    end else if (frame == FW'(MAX_FRAMES - 1)) begin
      frame_next = '0;
    end else begin
      frame_next = frame + 1'b1;
    end
  end

  // A byte ends after its fourth pair unless a terminator still follows.
  assign run_end = is_term || ((slot == SLOT_LAST) && (!head.last_byte || wrap));
  assign restart = run_end && head.last_byte;
  assign pop     = step && run_end;
  assign frame_ext = {8'd0, frame};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      cur_x <= TOP_X_FIRST;
      cur_y <= '0;
      frame <= '0;
      slot  <= SLOT_FIRST;
    end else if (step) begin
      if (restart) begin
        pos   <= '0;
        cur_x <= TOP_X_FIRST;
        cur_y <= '0;
        frame <= '0;
      end else begin
        pos   <= pos_next;
        cur_x <= x_next;
        cur_y <= y_next;
        frame <= frame_next;
      end
      slot <= run_end ? SLOT_FIRST : slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.frame_index <= frame_ext[7:0];
      result.cell_x      <= cur_x;
      result.cell_y      <= cur_y;
      result.symbol_code <= sym;
      result.blue_level  <= (sym == SYM_BLUE)  ? LEVEL_ON : 8'd0;
      result.green_level <= (sym == SYM_GREEN) ? LEVEL_ON : 8'd0;
      result.red_level   <= (sym == SYM_RED)   ? LEVEL_ON : 8'd0;
      result.end_symbol  <= is_term;
      result.last_of_run <= run_end;
    end
  end

endmodule

// File: dv/tb_four_color_cell_mapper.sv
// ----------------------------------------------------------------------------
// tb_four_color_cell_mapper
// Self-checking testbench for the four color cell mapper.
// ----------------------------------------------------------------------------
// Message bytes go in on the slave stream. A scoreboard object predicts,
// for every accepted byte, the cell transfers that it must cause: the four
// symbols with their colors and cell positions, and after a final byte the
// terminator when the frame still has room. Every output transfer is
// compared field by field with the oldest prediction. The run starts with
// a few hand-picked bytes, goes on with random messages under random
// idling on both sides (including one long hold-off of the output), and
// ends with one longer message at full rate.
// ----------------------------------------------------------------------------
module tb_four_color_cell_mapper;
  import fccm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAMES = MAX_FRAMES_DEF;
  // The longest correct run stays well under this limit.
  localparam int LIMIT_CYCLES = 200_000;
  localparam int RANDOM_BYTES = 190;
  localparam int FULL_RATE_BYTES = 48;
  localparam int HOLD_OFF_CYCLES = 300;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  // Set for the last part of the run, where neither side idles.
  bit full_rate;
  bit hold_off_done;

  four_color_cell_mapper #(
    .MAX_FRAMES(MAX_FRAMES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // Keeps its own copy of the cell position and the frame number, and the
  // queue of cells that the block still owes.
  class cell_scoreboard;
    localparam int TOP_COLS = 24;
    localparam int SIDE_COLS = 6;

    result_t     owed_cells[$];
    logic [10:0] next_cell;
    int unsigned frame_no;
    int unsigned errors;
    int unsigned results_seen;

    function new();
      next_cell = '0;
      frame_no = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    // Top-left pixel of a cell: top block first, then the right and the
    // left side blocks, each walked row by row.
    function void cell_origin(input logic [10:0] pos, output logic [9:0] x,
                              output logic [9:0] y);
      int unsigned p;
      p = 32'(pos);
      if (p < TOP_CELLS) begin
        y = 10'((p / TOP_COLS) * CELL_SIZE);
        x = 10'((p % TOP_COLS) * CELL_SIZE + TOP_X_FIRST);
      end else if (p < RIGHT_END) begin
        p = p - TOP_CELLS;
        y = 10'((p / SIDE_COLS) * CELL_SIZE + SIDE_Y_FIRST);
        x = 10'((p % SIDE_COLS) * CELL_SIZE + RIGHT_X_FIRST);
      end else begin
        p = p - RIGHT_END;
        y = 10'((p / SIDE_COLS) * CELL_SIZE + SIDE_Y_FIRST);
        x = 10'((p % SIDE_COLS) * CELL_SIZE + LEFT_X_FIRST);
      end
    endfunction

    function void owe_cell(input logic [1:0] sym, input logic term);
      result_t r;
      logic [9:0] x, y;
      cell_origin(next_cell, x, y);
      r.frame_index = frame_no[7:0];
      r.cell_x = x;
      r.cell_y = y;
      r.symbol_code = sym;
      r.blue_level = (sym == SYM_BLUE) ? LEVEL_ON : 8'd0;
      r.green_level = (sym == SYM_GREEN) ? LEVEL_ON : 8'd0;
      r.red_level = (sym == SYM_RED) ? LEVEL_ON : 8'd0;
      r.end_symbol = term;
      r.last_of_run = 1'b0;
      owed_cells = {owed_cells, r};
      if (next_cell == CELLS_LAST) begin
        next_cell = '0;
        frame_no = (frame_no + 1) % MAX_FRAMES;
      end else begin
        next_cell = next_cell + 11'd1;
      end
    endfunction

    // Called once per accepted byte.
    function void note_byte(input logic [7:0] data, input logic last);
      for (int k = 3; k >= 0; k--) begin
        owe_cell(data[2*k +: 2], 1'b0);
      end
      if (last) begin
        // The terminator only fits when the frame has a free cell left.
        if (next_cell != 0) begin
          owe_cell(SYM_BLACK, 1'b1);
        end
        next_cell = '0;
        frame_no = 0;
      end
      owed_cells[owed_cells.size() - 1].last_of_run = 1'b1;
    endfunction

    function void compare(input string field, input int unsigned want,
                          input int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    // Called once per accepted output transfer.
    function void check_result(input logic [TDATA_OUT_W-1:0] tdata,
                               input logic tuser, input logic tlast);
      result_t want;
      results_seen++;
      if (owed_cells.size() == 0) begin
        errors++;
        $display("%0t: transfer with nothing expected, got tdata %h user %b last %b",
                 $time, tdata, tuser, tlast);
        return;
      end
      want = owed_cells.pop_front();
      compare("frame_index", want.frame_index, tdata[7:0]);
      compare("cell_x", want.cell_x, tdata[17:8]);
      compare("cell_y", want.cell_y, tdata[27:18]);
      compare("symbol_code", want.symbol_code, tdata[29:28]);
      compare("blue_level", want.blue_level, tdata[37:30]);
      compare("green_level", want.green_level, tdata[45:38]);
      compare("red_level", want.red_level, tdata[53:46]);
      compare("tdata zero fill", 0, tdata[55:54]);
      compare("end_symbol", want.end_symbol, tuser);
      compare("last_of_run", want.last_of_run, tlast);
    endfunction
  endclass

  cell_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one byte, sometimes after a random gap, and holds it until the
  // block takes it. The handshake is sampled in the active region of the
  // edge, so it sees the values that the edge itself saw.
  task automatic send_byte(input logic [7:0] data, input logic last);
    if (!full_rate && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(data, last);
  endtask

  // A message of random bytes; only its final byte carries tlast.
  task automatic send_message(input int unsigned length);
    for (int unsigned i = 0; i < length; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == length - 1);
    end
  endtask

  // Output side: checks every transfer, then decides tready for the next
  // edge. Random stalls come in bursts; once during the random part the
  // output holds off long enough for the input queue to fill up.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_result(m_tdata, m_tuser, m_tlast);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!hold_off_done && sb.results_seen >= 120) begin
        hold_off_done = 1'b1;
        stall_left = HOLD_OFF_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (!full_rate && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Ends the run if the block stops making progress.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_sent;
    int unsigned length;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed bytes: all-zero and all-one bytes, each color in every
    // symbol slot, a message ending with a terminator, and single-byte
    // messages, each of which starts again at cell 0 of frame 0.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h1B, 1'b0);
    send_byte(8'hE4, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hC6, 1'b0);
    send_byte(8'h39, 1'b1);

    // Random messages, mostly short, a few longer ones.
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      length = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
                                           : $urandom_range(1, 8);
      send_message(length);
      random_sent += length;
    end

    // Last part at full rate: one longer message that ends with a
    // terminator.
    full_rate = 1'b1;
    send_message(FULL_RATE_BYTES);
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;

    while (sb.owed_cells.size() != 0) @(posedge clk);
    // A few more cycles so that a stray extra transfer is still caught.
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/fccm_pkg.sv
hw/rtl/fccm_front.sv
hw/rtl/fccm_back.sv
hw/rtl/four_color_cell_mapper.sv
dv/tb_four_color_cell_mapper.sv
